// ===== hdl/fcpc_pkg.sv =====
// Package for the four-channel period capture block: types, constants, helpers.
`default_nettype none
package fcpc_pkg;

	localparam int DATA_W     = 32;
	localparam int CNT_W      = 16;
	localparam int TIMER_BITS = 16;
	localparam int CH_W       = 2;
	localparam int NUM_W      = 38;   // 60 * upper
	localparam int DEN_W      = 35;   // 7 * period
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int CHANNELS_DEF = 4;

	localparam logic [DATA_W-1:0] UPPER_RST  = 32'd1000000;
	localparam logic [DATA_W-1:0] LOWER_RST  = 32'd100;
	localparam logic [CNT_W-1:0]  EXPIRY_RST = 16'd5;
	localparam logic [DATA_W-1:0] PERIOD_RST = 32'd1000001;

	localparam logic CMD_OVERFLOW = 1'b0;
	localparam logic CMD_CAPTURE  = 1'b1;

	typedef enum logic [1:0] {
		REG_UPPER  = 2'd0,
		REG_LOWER  = 2'd1,
		REG_EXPIRY = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fcpc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module fcpc_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  fcpc_pkg::div_req_t    req,
	output fcpc_pkg::div_rsp_t    rsp
);
	import fcpc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W:0]       shifted;
	logic [DEN_W:0]       den_ext;
	logic                 ge;
	logic [DEN_W:0]       diff;
	logic [DEN_W-1:0]     rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[NUM_W-1]};
		den_ext  = {1'b0, den_q};
		ge       = (shifted >= den_ext);
		diff     = shifted - den_ext;
		rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule
`default_nettype wire

// ===== hdl/four_channel_period_capture.sv =====
// Top level: per-channel period capture with serial rpm divider and APB registers.
//
//  port group | dir | contents
//  -----------+-----+-------------------------------------------------
//  s_*        | in  | capture/overflow request (tuser = command)
//  m_*        | out | channel report (tuser = period_updated)
//  p*         | cfg | APB: upper limit @0x0, lower limit @0x4, expiry @0x8
//
// A request passes from accept to result register through an update state, an
// operand state that starts the serial divider, the divider's bit steps, and a
// state that sees it finish and loads the result. The next accept can follow in
// the cycle after the load; no new request is taken before. Reset restores the
// register defaults and all channel state at once. A result waiting in the
// output register does not block the next accept; the next result waits for it.
`default_nettype none
module four_channel_period_capture #(
	parameter int CHANNELS = fcpc_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // channel[1:0], capture_count[17:2], zero pad
	input  wire logic        s_tuser,   // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // report_channel[1:0], period_ticks[33:2], rpm[65:34]
	output logic             m_tuser,   // period_updated
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import fcpc_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q, state_d;

	logic [DATA_W-1:0]     upper_q;
	logic [DATA_W-1:0]     lower_q;
	logic [CNT_W-1:0]      expiry_q;

	logic [TIMER_BITS-1:0] start_q  [CHANNELS];
	logic [CNT_W-1:0]      ovf_q    [CHANNELS];
	logic [CNT_W-1:0]      exp_q    [CHANNELS];
	logic [DATA_W-1:0]     period_q [CHANNELS];
	logic [CHANNELS-1:0]   enable_q;
	logic [CNT_W-1:0]      exp_inc  [CHANNELS];

	logic                  cmd_q;
	logic [CH_W-1:0]       ch_q;
	logic [TIMER_BITS-1:0] now_q;
	logic                  upd_q;
	logic [DATA_W-1:0]     rep_period_q;
	logic                  rpm_zero_q;

	logic                  m_tvalid_q;
	logic [71:0]           m_tdata_q;
	logic                  m_tuser_q;

	logic [IDX_W-1:0]      idx;
	logic                  ch_ok;
	logic [DATA_W-1:0]     stopped;
	logic [DATA_W:0]       meas;
	logic                  meas_ok;
	logic                  wr_en;
	logic                  in_acc;
	logic                  out_load;
	logic [DATA_W-1:0]     cur_period;
	logic [DATA_W-1:0]     rpm;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	// configuration
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= UPPER_RST;
			lower_q  <= LOWER_RST;
			expiry_q <= EXPIRY_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_UPPER:  upper_q  <= pwdata;
				REG_LOWER:  lower_q  <= pwdata;
				REG_EXPIRY: expiry_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_UPPER:  prdata = upper_q;
			REG_LOWER:  prdata = lower_q;
			REG_EXPIRY: prdata = {{(DATA_W-CNT_W){1'b0}}, expiry_q};
			default:    prdata = '0;
		endcase
	end

	// datapath helpers
	assign idx        = IDX_W'(ch_q);
	assign ch_ok      = (32'(ch_q) < CHANNELS);
	assign stopped    = (&upper_q) ? upper_q : upper_q + 1'b1;
	assign meas       = {1'b0, ovf_q[idx], now_q} - {{(DATA_W-TIMER_BITS+1){1'b0}}, start_q[idx]};
	assign meas_ok    = !meas[DATA_W] && (meas[DATA_W-1:0] > lower_q);
	assign cur_period = ch_ok ? period_q[idx] : '0;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			exp_inc[i] = sat_inc(exp_q[i]);
		end
	end

	// sequencer
	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = ({6'b0, upper_q} << 6) - ({6'b0, upper_q} << 2);
		div_req.den   = ({3'b0, cur_period} << 3) - {3'b0, cur_period};
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_EVAL;
			end
			ST_EVAL: state_d = ST_PREP;
			ST_PREP: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// request capture and per-report operands
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= s_tuser;
			ch_q  <= s_tdata[1:0];
			now_q <= s_tdata[17:2];
		end
		if (state_q == ST_PREP) begin
			rep_period_q <= cur_period;
			rpm_zero_q   <= !ch_ok || (cur_period > upper_q) || (cur_period == '0);
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '1;
			upd_q    <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				start_q[i]  <= '0;
				ovf_q[i]    <= '0;
				exp_q[i]    <= '0;
				period_q[i] <= PERIOD_RST;
			end
		end else if (state_q == ST_EVAL) begin
			upd_q <= 1'b0;
			if (cmd_q == CMD_OVERFLOW) begin
				enable_q <= '1;
				for (int i = 0; i < CHANNELS; i++) begin
					ovf_q[i] <= sat_inc(ovf_q[i]);
					exp_q[i] <= exp_inc[i];
					if (exp_inc[i] > expiry_q) period_q[i] <= stopped;
				end
			end else if (ch_ok && enable_q[idx]) begin
				exp_q[idx] <= '0;
				if (start_q[idx] == '0) begin
					start_q[idx] <= now_q;
					ovf_q[idx]   <= '0;
				end else if (now_q != '0 && meas_ok) begin
					period_q[idx] <= meas[DATA_W-1:0];
					start_q[idx]  <= '0;
					ovf_q[idx]    <= '0;
					enable_q[idx] <= 1'b0;
					upd_q         <= 1'b1;
				end
			end
		end
	end

	fcpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign rpm = rpm_zero_q ? '0 :
		(|div_rsp.quot[NUM_W-1:DATA_W]) ? '1 : div_rsp.quot[DATA_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'b0, rpm, rep_period_q, ch_q};
			m_tuser_q <= upd_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a request while busy");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside its state");

	a_rpm_zero_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:2] > upper_q |-> m_tdata[65:34] == '0)
		else $error("nonzero rpm for a stopped channel");

	a_updated_above_lower: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[33:2] > lower_q)
		else $error("stored period not above lower limit");

endmodule
`default_nettype wire
